@@ src/jst_pkg.sv @@
package jst_pkg;

  localparam int MAX_NEST = 64;
  localparam int NEST_W = $clog2(MAX_NEST + 2);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int MAX_RES = 4;

  localparam logic CFG_MAX_DEPTH = 1'b0;
  localparam logic CFG_REQUIRE_EOF = 1'b1;

  typedef enum logic [3:0] {
    EV_OBJ_OPEN  = 4'd0,
    EV_OBJ_CLOSE = 4'd1,
    EV_ARR_OPEN  = 4'd2,
    EV_ARR_CLOSE = 4'd3,
    EV_KEY_BYTE  = 4'd4,
    EV_KEY_END   = 4'd5,
    EV_STR_BYTE  = 4'd6,
    EV_STR_END   = 4'd7,
    EV_NUM_BYTE  = 4'd8,
    EV_NUM_END   = 4'd9,
    EV_TRUE      = 4'd10,
    EV_FALSE     = 4'd11,
    EV_NULL      = 4'd12,
    EV_DONE      = 4'd13,
    EV_ERROR     = 4'd14
  } ev_e;

  localparam logic [4:0] ERR_TRAILING   = 5'd0;
  localparam logic [4:0] ERR_LITERAL    = 5'd1;
  localparam logic [4:0] ERR_DEPTH      = 5'd2;
  localparam logic [4:0] ERR_NO_VALUE   = 5'd3;
  localparam logic [4:0] ERR_KEY        = 5'd4;
  localparam logic [4:0] ERR_COLON      = 5'd5;
  localparam logic [4:0] ERR_OBJ_SEP    = 5'd6;
  localparam logic [4:0] ERR_ARR_SEP    = 5'd7;
  localparam logic [4:0] ERR_HEX_SHORT  = 5'd8;
  localparam logic [4:0] ERR_HEX_DIGIT  = 5'd9;
  localparam logic [4:0] ERR_STR_OPEN   = 5'd10;
  localparam logic [4:0] ERR_ESC_OPEN   = 5'd11;
  localparam logic [4:0] ERR_LOW_SURR   = 5'd12;
  localparam logic [4:0] ERR_HIGH_ALONE = 5'd13;
  localparam logic [4:0] ERR_LOW_ALONE  = 5'd14;
  localparam logic [4:0] ERR_ESCAPE     = 5'd15;
  localparam logic [4:0] ERR_CTRL       = 5'd16;
  localparam logic [4:0] ERR_UTF8       = 5'd17;
  localparam logic [4:0] ERR_NUM_SHORT  = 5'd18;
  localparam logic [4:0] ERR_NUMBER     = 5'd19;
  localparam logic [4:0] ERR_FRAC       = 5'd20;
  localparam logic [4:0] ERR_EXP        = 5'd21;

  typedef struct packed {
    ev_e         ev;
    logic [7:0]  data;
    logic [6:0]  lvl;
    logic [4:0]  code;
    logic [31:0] off;
    logic [31:0] line;
    logic [31:0] col;
  } res_t;

  typedef struct packed {
    logic [2:0]         cnt;
    res_t [MAX_RES-1:0] r;
  } bundle_t;

  function automatic res_t mk_res(ev_e ev, logic [7:0] data, logic [6:0] lvl);
    res_t r;
    r.ev   = ev;
    r.data = data;
    r.lvl  = lvl;
    r.code = '0;
    r.off  = '0;
    r.line = 32'd1;
    r.col  = 32'd1;
    return r;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (i)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (i)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

@@ src/jst_front.sv @@
module jst_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                take_i,
  input  logic                func_i,
  input  logic [7:0]          byte_i,
  output logic                push_o,
  output jst_pkg::bundle_t    bundle_o
);

  typedef enum logic [26:0] {
    M_VALUE     = 27'b1 << 0,
    M_ARR_FIRST = 27'b1 << 1,
    M_OBJ_FIRST = 27'b1 << 2,
    M_KEY       = 27'b1 << 3,
    M_COLON     = 27'b1 << 4,
    M_AFTER     = 27'b1 << 5,
    M_IGNORE    = 27'b1 << 6,
    M_LIT_T     = 27'b1 << 7,
    M_LIT_F     = 27'b1 << 8,
    M_LIT_N     = 27'b1 << 9,
    M_STR       = 27'b1 << 10,
    M_ESC       = 27'b1 << 11,
    M_HEX       = 27'b1 << 12,
    M_LOWHEX    = 27'b1 << 13,
    M_NEEDBS    = 27'b1 << 14,
    M_NEEDU     = 27'b1 << 15,
    M_UTF2      = 27'b1 << 16,
    M_UTF3      = 27'b1 << 17,
    M_UTF4      = 27'b1 << 18,
    M_NSIGN     = 27'b1 << 19,
    M_NZERO     = 27'b1 << 20,
    M_NINT      = 27'b1 << 21,
    M_NDOT      = 27'b1 << 22,
    M_NFRAC     = 27'b1 << 23,
    M_NEXP      = 27'b1 << 24,
    M_NESIGN    = 27'b1 << 25,
    M_NEXPD     = 27'b1 << 26
  } mode_e;

  typedef enum logic [2:0] {
    POS_CUR  = 3'b001,
    POS_NXT  = 3'b010,
    POS_MARK = 3'b100
  } pos_e;

  localparam int NW = jst_pkg::NEST_W;

  mode_e                      mode_q, mode_d, m;
  logic [jst_pkg::MAX_NEST:0] stack_q, stack_d;
  logic [NW-1:0]              open_q, open_d;
  logic [31:0]                off_q, off_d, line_q, line_d, col_q, col_d;
  logic [31:0]                moff_q, moff_d, mline_q, mline_d, mcol_q, mcol_d;
  logic [20:0]                acc_q, acc_d;
  logic [9:0]                 hh_q, hh_d;
  logic [2:0]                 pend_q, pend_d;
  logic [2:0]                 lit_q, lit_d;
  logic                       fail_q, fail_d;
  logic [6:0]                 max_depth_q;
  logic                       req_eof_q;

  logic [31:0] nxt_off, nxt_line, nxt_col, lim;
  logic [7:0]  c;
  logic        ws, dig, expo, num_mode, redo, sv, do_close, utf_go, err, obj, hex_ok;
  logic [4:0]  err_code;
  pos_e        err_pos;
  logic [20:0] cp, acc_n;
  logic [15:0] hx;
  logic [3:0]  h;
  logic [2:0]  n;
  logic [1:0]  k;
  mode_e       num_next;
  jst_pkg::ev_e sev;
  jst_pkg::res_t [jst_pkg::MAX_RES-1:0] res;
  jst_pkg::res_t er;

  assign c    = byte_i;
  assign ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign dig  = (c >= "0") && (c <= "9");
  assign expo = (c == "e") || (c == "E");
  assign obj  = stack_q[0];
  assign lim  = (32'(max_depth_q) > 32'(jst_pkg::MAX_NEST)) ?
                32'(jst_pkg::MAX_NEST) : 32'(max_depth_q);
  assign sev  = (lit_q != 3'd0) ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE;

  assign nxt_off  = (off_q == 32'hFFFF_FFFF) ? off_q : off_q + 32'd1;
  assign nxt_line = (c == 8'h0A && line_q != 32'hFFFF_FFFF) ? line_q + 32'd1 : line_q;
  assign nxt_col  = (c == 8'h0A) ? 32'd1 :
                    ((col_q == 32'hFFFF_FFFF) ? col_q : col_q + 32'd1);

  always_comb begin
    if (dig) begin
      h = 4'(c - "0");
      hex_ok = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      h = 4'(c - "a" + 8'd10);
      hex_ok = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      h = 4'(c - "A" + 8'd10);
      hex_ok = 1'b1;
    end else begin
      h = 4'd0;
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_d = mode_q; stack_d = stack_q; open_d = open_q;
    off_d = off_q; line_d = line_q; col_d = col_q;
    moff_d = moff_q; mline_d = mline_q; mcol_d = mcol_q;
    acc_d = acc_q; hh_d = hh_q; pend_d = pend_q; lit_d = lit_q; fail_d = fail_q;
    res = '0; n = 3'd0;
    redo = 1'b0; sv = 1'b0; do_close = 1'b0; utf_go = 1'b0; cp = '0;
    err = 1'b0; err_code = jst_pkg::ERR_TRAILING; err_pos = POS_CUR;
    num_next = mode_q; acc_n = '0; hx = '0; k = 2'd0;
    num_mode = (mode_q == M_NSIGN) || (mode_q == M_NZERO) || (mode_q == M_NINT) ||
               (mode_q == M_NDOT) || (mode_q == M_NFRAC) || (mode_q == M_NEXP) ||
               (mode_q == M_NESIGN) || (mode_q == M_NEXPD);
    m = mode_q;
    er = '0;

    if (take_i && !func_i) begin
      if (!fail_q) begin
        if (num_mode) begin
          unique case (mode_q)
            M_NSIGN: begin
              if (c == "0") num_next = M_NZERO;
              else if (dig) num_next = M_NINT;
              else begin err = 1'b1; err_code = jst_pkg::ERR_NUMBER; end
            end
            M_NZERO, M_NINT: begin
              if (dig && mode_q == M_NINT) num_next = M_NINT;
              else if (c == ".") num_next = M_NDOT;
              else if (expo) num_next = M_NEXP;
              else redo = 1'b1;
            end
            M_NDOT: begin
              if (dig) num_next = M_NFRAC;
              else begin err = 1'b1; err_code = jst_pkg::ERR_FRAC; end
            end
            M_NFRAC: begin
              if (dig) num_next = M_NFRAC;
              else if (expo) num_next = M_NEXP;
              else redo = 1'b1;
            end
            M_NEXP, M_NESIGN: begin
              if (dig) num_next = M_NEXPD;
              else if (mode_q == M_NEXP && (c == "+" || c == "-")) num_next = M_NESIGN;
              else begin err = 1'b1; err_code = jst_pkg::ERR_EXP; end
            end
            default: begin
              if (dig) num_next = M_NEXPD;
              else redo = 1'b1;
            end
          endcase
          if (redo) begin
            res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_NUM_END, 8'h00, 7'(open_q));
            n = n + 3'd1;
            mode_d = M_AFTER;
            m = M_AFTER;
          end else if (!err) begin
            res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_NUM_BYTE, c, 7'(open_q));
            n = n + 3'd1;
            mode_d = num_next;
          end
        end

        if (!num_mode || redo) begin
          unique case (m)
            M_VALUE: sv = !ws;
            M_ARR_FIRST: begin
              if (!ws) begin
                if (c == "]") do_close = 1'b1;
                else sv = 1'b1;
              end
            end
            M_OBJ_FIRST, M_KEY: begin
              if (!ws) begin
                if (c == "}" && m == M_OBJ_FIRST) do_close = 1'b1;
                else if (c == 8'h22) begin lit_d = 3'd1; mode_d = M_STR; end
                else begin err = 1'b1; err_code = jst_pkg::ERR_KEY; end
              end
            end
            M_COLON: begin
              if (!ws) begin
                if (c == ":") mode_d = M_VALUE;
                else begin err = 1'b1; err_code = jst_pkg::ERR_COLON; end
              end
            end
            M_AFTER: begin
              if (open_q == '0) begin
                if (!req_eof_q) mode_d = M_IGNORE;
                else if (!ws) begin err = 1'b1; err_code = jst_pkg::ERR_TRAILING; end
              end else if (!ws) begin
                if (c == ",") mode_d = obj ? M_KEY : M_VALUE;
                else if (c == (obj ? 8'h7D : 8'h5D)) do_close = 1'b1;
                else begin
                  err = 1'b1;
                  err_code = obj ? jst_pkg::ERR_OBJ_SEP : jst_pkg::ERR_ARR_SEP;
                end
              end
            end
            M_LIT_T, M_LIT_F, M_LIT_N: begin
              k = (m == M_LIT_T) ? 2'd0 : ((m == M_LIT_F) ? 2'd1 : 2'd2);
              if (lit_q >= jst_pkg::lit_len(k) || c != jst_pkg::lit_char(k, lit_q)) begin
                err = 1'b1; err_code = jst_pkg::ERR_LITERAL; err_pos = POS_MARK;
              end else begin
                lit_d = lit_q + 3'd1;
                if (lit_d == jst_pkg::lit_len(k)) begin
                  unique case (k)
                    2'd0: res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_TRUE, 8'h00, 7'(open_q));
                    2'd1: res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_FALSE, 8'h00, 7'(open_q));
                    default: res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_NULL, 8'h00, 7'(open_q));
                  endcase
                  n = n + 3'd1;
                  mode_d = M_AFTER;
                end
              end
            end
            M_STR: begin
              if (c == 8'h22) begin
                res[n[1:0]] = jst_pkg::mk_res((lit_q != 3'd0) ? jst_pkg::EV_KEY_END :
                                              jst_pkg::EV_STR_END, 8'h00, 7'(open_q));
                n = n + 3'd1;
                mode_d = (lit_q != 3'd0) ? M_COLON : M_AFTER;
              end else if (c == 8'h5C) begin
                mode_d = M_ESC;
              end else if (c < 8'h20) begin
                err = 1'b1; err_code = jst_pkg::ERR_CTRL;
              end else if (c < 8'h80) begin
                res[n[1:0]] = jst_pkg::mk_res(sev, c, 7'(open_q));
                n = n + 3'd1;
              end else if (c >= 8'hC2 && c <= 8'hDF) begin
                moff_d = off_q; mline_d = line_q; mcol_d = col_q;
                acc_d = 21'(c[4:0]); pend_d = 3'd1; mode_d = M_UTF2;
              end else if (c >= 8'hE0 && c <= 8'hEF) begin
                moff_d = off_q; mline_d = line_q; mcol_d = col_q;
                acc_d = 21'(c[3:0]); pend_d = 3'd2; mode_d = M_UTF3;
              end else if (c >= 8'hF0 && c <= 8'hF7) begin
                moff_d = off_q; mline_d = line_q; mcol_d = col_q;
                acc_d = 21'(c[2:0]); pend_d = 3'd3; mode_d = M_UTF4;
              end else begin
                err = 1'b1; err_code = jst_pkg::ERR_UTF8;
              end
            end
            M_ESC: begin
              mode_d = M_STR;
              priority case (c)
                8'h22, 8'h5C, "/": begin
                  res[n[1:0]] = jst_pkg::mk_res(sev, c, 7'(open_q)); n = n + 3'd1;
                end
                "b": begin res[n[1:0]] = jst_pkg::mk_res(sev, 8'h08, 7'(open_q)); n = n + 3'd1; end
                "f": begin res[n[1:0]] = jst_pkg::mk_res(sev, 8'h0C, 7'(open_q)); n = n + 3'd1; end
                "n": begin res[n[1:0]] = jst_pkg::mk_res(sev, 8'h0A, 7'(open_q)); n = n + 3'd1; end
                "r": begin res[n[1:0]] = jst_pkg::mk_res(sev, 8'h0D, 7'(open_q)); n = n + 3'd1; end
                "t": begin res[n[1:0]] = jst_pkg::mk_res(sev, 8'h09, 7'(open_q)); n = n + 3'd1; end
                "u": begin
                  acc_d = '0; pend_d = 3'd4; mode_d = M_HEX;
                  moff_d = nxt_off; mline_d = nxt_line; mcol_d = nxt_col;
                end
                default: begin
                  err = 1'b1; err_code = jst_pkg::ERR_ESCAPE; err_pos = POS_NXT;
                end
              endcase
            end
            M_HEX, M_LOWHEX: begin
              if (!hex_ok) begin
                err = 1'b1; err_code = jst_pkg::ERR_HEX_DIGIT; err_pos = POS_MARK;
              end else begin
                hx = {acc_q[11:0], h};
                acc_d = 21'(hx);
                pend_d = pend_q - 3'd1;
                if (pend_d == 3'd0) begin
                  if (m == M_LOWHEX) begin
                    if (hx < 16'hDC00 || hx > 16'hDFFF) begin
                      err = 1'b1; err_code = jst_pkg::ERR_LOW_SURR; err_pos = POS_NXT;
                    end else begin
                      utf_go = 1'b1;
                      cp = 21'h10000 + {1'b0, hh_q, 10'h000} + 21'(hx - 16'hDC00);
                    end
                  end else if (hx >= 16'hD800 && hx <= 16'hDBFF) begin
                    hh_d = 10'(hx - 16'hD800);
                    mode_d = M_NEEDBS;
                  end else if (hx >= 16'hDC00 && hx <= 16'hDFFF) begin
                    err = 1'b1; err_code = jst_pkg::ERR_LOW_ALONE; err_pos = POS_NXT;
                  end else begin
                    utf_go = 1'b1; cp = 21'(hx);
                  end
                end
              end
            end
            M_NEEDBS: begin
              if (c == 8'h5C) begin
                moff_d = off_q; mline_d = line_q; mcol_d = col_q; mode_d = M_NEEDU;
              end else begin
                err = 1'b1; err_code = jst_pkg::ERR_HIGH_ALONE;
              end
            end
            M_NEEDU: begin
              if (c == "u") begin
                acc_d = '0; pend_d = 3'd4; mode_d = M_LOWHEX;
                moff_d = nxt_off; mline_d = nxt_line; mcol_d = nxt_col;
              end else begin
                err = 1'b1; err_code = jst_pkg::ERR_HIGH_ALONE; err_pos = POS_MARK;
              end
            end
            M_UTF2, M_UTF3, M_UTF4: begin
              if (c[7:6] != 2'b10) begin
                err = 1'b1; err_code = jst_pkg::ERR_UTF8; err_pos = POS_MARK;
              end else begin
                acc_n = {acc_q[14:0], c[5:0]};
                acc_d = acc_n;
                pend_d = pend_q - 3'd1;
                if (pend_d == 3'd0) begin
                  if ((m == M_UTF3 && (acc_n < 21'h800 ||
                       (acc_n >= 21'hD800 && acc_n <= 21'hDFFF))) ||
                      (m == M_UTF4 && (acc_n < 21'h10000 || acc_n > 21'h10FFFF))) begin
                    err = 1'b1; err_code = jst_pkg::ERR_UTF8; err_pos = POS_MARK;
                  end else begin
                    utf_go = 1'b1; cp = acc_n;
                  end
                end
              end
            end
            default: ;
          endcase
        end

        if (sv) begin
          if (32'(open_q) > lim) begin
            err = 1'b1; err_code = jst_pkg::ERR_DEPTH;
          end else if (c == "{" || c == "[") begin
            if (32'(open_q) > 32'(jst_pkg::MAX_NEST)) begin
              err = 1'b1; err_code = jst_pkg::ERR_DEPTH;
            end else begin
              res[n[1:0]] = jst_pkg::mk_res((c == "{") ? jst_pkg::EV_OBJ_OPEN :
                                            jst_pkg::EV_ARR_OPEN, 8'h00, 7'(open_q));
              n = n + 3'd1;
              stack_d = {stack_q[jst_pkg::MAX_NEST-1:0], c == "{"};
              open_d = open_q + 1'b1;
              mode_d = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
            end
          end else if (c == 8'h22) begin
            lit_d = 3'd0; mode_d = M_STR;
          end else if (c == "t" || c == "f" || c == "n") begin
            moff_d = off_q; mline_d = line_q; mcol_d = col_q;
            lit_d = 3'd1;
            mode_d = (c == "t") ? M_LIT_T : ((c == "f") ? M_LIT_F : M_LIT_N);
          end else if (c == "-" || dig) begin
            res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_NUM_BYTE, c, 7'(open_q));
            n = n + 3'd1;
            mode_d = (c == "-") ? M_NSIGN : ((c == "0") ? M_NZERO : M_NINT);
          end else begin
            err = 1'b1; err_code = jst_pkg::ERR_NUMBER;
          end
        end

        if (do_close) begin
          open_d = open_q - 1'b1;
          res[n[1:0]] = jst_pkg::mk_res(obj ? jst_pkg::EV_OBJ_CLOSE : jst_pkg::EV_ARR_CLOSE,
                                        8'h00, 7'(open_d));
          n = n + 3'd1;
          stack_d = {1'b0, stack_q[jst_pkg::MAX_NEST:1]};
          mode_d = M_AFTER;
        end

        // A code point goes out as one to four UTF-8 bytes.
        if (utf_go) begin
          mode_d = M_STR;
          if (cp < 21'h80) begin
            res[n[1:0]] = jst_pkg::mk_res(sev, cp[7:0], 7'(open_q)); n = n + 3'd1;
          end else if (cp < 21'h800) begin
            res[n[1:0]] = jst_pkg::mk_res(sev, {3'b110, cp[10:6]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[5:0]}, 7'(open_q)); n = n + 3'd1;
          end else if (cp < 21'h10000) begin
            res[n[1:0]] = jst_pkg::mk_res(sev, {4'b1110, cp[15:12]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[11:6]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[5:0]}, 7'(open_q)); n = n + 3'd1;
          end else begin
            res[n[1:0]] = jst_pkg::mk_res(sev, {5'b11110, cp[20:18]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[17:12]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[11:6]}, 7'(open_q)); n = n + 3'd1;
            res[n[1:0]] = jst_pkg::mk_res(sev, {2'b10, cp[5:0]}, 7'(open_q)); n = n + 3'd1;
          end
        end
      end
      off_d = nxt_off; line_d = nxt_line; col_d = nxt_col;
    end else if (take_i && func_i) begin
      if (!fail_q) begin
        if (mode_q == M_NZERO || mode_q == M_NINT || mode_q == M_NFRAC ||
            mode_q == M_NEXPD) begin
          res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_NUM_END, 8'h00, 7'(open_q));
          n = n + 3'd1;
          m = M_AFTER;
        end
        unique case (m)
          M_VALUE, M_ARR_FIRST: begin
            err = 1'b1;
            err_code = (32'(open_q) > lim) ? jst_pkg::ERR_DEPTH : jst_pkg::ERR_NO_VALUE;
          end
          M_OBJ_FIRST, M_KEY: begin err = 1'b1; err_code = jst_pkg::ERR_KEY; end
          M_COLON: begin err = 1'b1; err_code = jst_pkg::ERR_COLON; end
          M_AFTER: begin
            if (open_q == '0) begin
              res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_DONE, 8'h00, 7'd0);
              n = n + 3'd1;
            end else begin
              err = 1'b1;
              err_code = obj ? jst_pkg::ERR_OBJ_SEP : jst_pkg::ERR_ARR_SEP;
            end
          end
          M_IGNORE: begin
            res[n[1:0]] = jst_pkg::mk_res(jst_pkg::EV_DONE, 8'h00, 7'd0);
            n = n + 3'd1;
          end
          M_LIT_T, M_LIT_F, M_LIT_N: begin
            err = 1'b1; err_code = jst_pkg::ERR_LITERAL; err_pos = POS_MARK;
          end
          M_STR: begin err = 1'b1; err_code = jst_pkg::ERR_STR_OPEN; end
          M_ESC: begin err = 1'b1; err_code = jst_pkg::ERR_ESC_OPEN; end
          M_HEX, M_LOWHEX: begin
            err = 1'b1; err_code = jst_pkg::ERR_HEX_SHORT; err_pos = POS_MARK;
          end
          M_NEEDBS: begin err = 1'b1; err_code = jst_pkg::ERR_HIGH_ALONE; end
          M_NEEDU: begin
            err = 1'b1; err_code = jst_pkg::ERR_HIGH_ALONE; err_pos = POS_MARK;
          end
          M_UTF2, M_UTF3, M_UTF4: begin
            err = 1'b1; err_code = jst_pkg::ERR_UTF8; err_pos = POS_MARK;
          end
          M_NSIGN: begin err = 1'b1; err_code = jst_pkg::ERR_NUM_SHORT; end
          M_NDOT: begin err = 1'b1; err_code = jst_pkg::ERR_FRAC; end
          default: begin err = 1'b1; err_code = jst_pkg::ERR_EXP; end
        endcase
      end
    end

    if (err) begin
      er.ev = jst_pkg::EV_ERROR;
      er.data = 8'h00;
      er.lvl = 7'(open_q);
      er.code = err_code;
      unique case (err_pos)
        POS_CUR:  begin er.off = off_q; er.line = line_q; er.col = col_q; end
        POS_NXT:  begin er.off = nxt_off; er.line = nxt_line; er.col = nxt_col; end
        default:  begin er.off = moff_q; er.line = mline_q; er.col = mcol_q; end
      endcase
      // At end of text, an error that would point at the next byte reports at the current position.
      if (func_i && err_pos == POS_NXT) begin
        er.off = off_q; er.line = line_q; er.col = col_q;
      end
      res[n[1:0]] = er;
      n = n + 3'd1;
      fail_d = 1'b1;
      mode_d = M_IGNORE;
    end

    if (take_i && func_i) begin
      mode_d = M_VALUE; open_d = '0;
      off_d = '0; line_d = 32'd1; col_d = 32'd1;
      moff_d = '0; mline_d = 32'd1; mcol_d = 32'd1;
      acc_d = '0; hh_d = '0; pend_d = '0; lit_d = '0; fail_d = 1'b0;
    end
  end

  assign push_o = take_i && (n != 3'd0);
  assign bundle_o.cnt = n;
  assign bundle_o.r = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_VALUE;
      open_q <= '0;
      off_q <= '0; line_q <= 32'd1; col_q <= 32'd1;
      moff_q <= '0; mline_q <= 32'd1; mcol_q <= 32'd1;
      acc_q <= '0; hh_q <= '0; pend_q <= '0; lit_q <= '0;
      fail_q <= 1'b0;
      max_depth_q <= 7'd64;
      req_eof_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
      open_q <= open_d;
      off_q <= off_d; line_q <= line_d; col_q <= col_d;
      moff_q <= moff_d; mline_q <= mline_d; mcol_q <= mcol_d;
      acc_q <= acc_d; hh_q <= hh_d; pend_q <= pend_d; lit_q <= lit_d;
      fail_q <= fail_d;
      if (cfg_we_i && cfg_index_i == jst_pkg::CFG_MAX_DEPTH) max_depth_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == jst_pkg::CFG_REQUIRE_EOF) req_eof_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
  end

endmodule

@@ src/jst_queue.sv @@
module jst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jst_pkg::bundle_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output jst_pkg::bundle_t head_o
);

  jst_pkg::bundle_t mem_q [jst_pkg::QDEPTH];
  logic [jst_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [jst_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (jst_pkg::QPTR_W + 1)'(jst_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ src/jst_back.sv @@
module jst_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  jst_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jst_pkg::res_t    res_o,
  output logic             last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o = avail_i;
  assign res_o  = head_i.r[idx_q];
  assign last_o = ((3'(idx_q) + 3'd1) == head_i.cnt);
  assign fire   = avail_i && !out_stall_i;
  assign pop_o  = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = last_o ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else idx_q <= idx_d;
  end

endmodule

@@ src/json_stream_tokenizer.sv @@
// Streaming JSON tokenizer: takes one text byte (func_i = 0) or an end-of-text marker
// (func_i = 1) per word and returns up to four event words per input word, the last marked
// by last_o. The parser front end accepts a word every cycle as long as its four-entry
// result queue has room; the back end hands out one event per cycle while out_stall_i
// is low, and sustained input rate is one word per cycle while each word yields at most
// one event. After an error, bytes are ignored and end of text produces no event; end of
// text always returns the parser to its reset state, apart from the configuration.
module json_stream_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [6:0]  nest_level_o,
  output logic [4:0]  error_code_o,
  output logic [31:0] error_offset_o,
  output logic [31:0] error_line_o,
  output logic [31:0] error_column_o,
  output logic        last_o
);

  jst_pkg::bundle_t bundle, head;
  jst_pkg::res_t    res;
  logic             push, pop, full, empty, take;

  assign in_stall_o = full;
  assign take = in_valid_i && !full;

  jst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .func_i      (func_i),
    .byte_i      (in_byte_i),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  jst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  jst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign event_res_o    = res.ev;
  assign data_byte_o    = res.data;
  assign nest_level_o   = res.lvl;
  assign error_code_o   = res.code;
  assign error_offset_o = res.off;
  assign error_line_o   = res.line;
  assign error_column_o = res.col;

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == jst_pkg::EV_DONE |-> last_o && nest_level_o == 7'd0)
    else $error("done event is not the final word at level zero");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == jst_pkg::EV_ERROR |-> last_o)
    else $error("error event is not the final word");

  a_error_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == jst_pkg::EV_ERROR |-> error_line_o != 32'd0 &&
    error_column_o != 32'd0)
    else $error("error position has a zero line or column");

endmodule
